// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication.
`define OKRGB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define OKRGB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hw/rtl/okrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// okrgb_pkg
// Shared types, fixed-point coefficients and constant tables of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package okrgb_pkg;

   localparam int TRIG_BITS  = 10;
   localparam int GAMMA_BITS = 10;
   localparam int TRIG_JW    = TRIG_BITS - 2;
   localparam int TRIG_Q     = 1 << TRIG_JW;
   localparam int GAMMA_Q    = 1 << GAMMA_BITS;
   localparam int GAMMA_IW   = GAMMA_BITS + 1;

   typedef logic [16:0] sin_rom_type [0:TRIG_Q];
   typedef logic [16:0] gamma_rom_type [0:GAMMA_Q];
   typedef longint unsigned taylor_div_type [1:7];

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam taylor_div_type TAYLOR_DIV = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210};

   // quarter-wave sine, Q1.16, from a Q30 Taylor sum
   function automatic sin_rom_type sin_table();
      sin_rom_type rom;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      s;
      for (int j = 0; j <= TRIG_Q; j++) begin
         x    = (64'(j) * HALF_PI_Q30 + (64'd1 << (TRIG_BITS - 3))) >> TRIG_JW;
         x2   = (x * x + (64'd1 << 29)) >> 30;
         term = x;
         s    = longint'(x);
         for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if (k % 2 == 1) s = s - longint'(term);
            else            s = s + longint'(term);
         end
         if (s < 0) s = 0;
         if (s > (longint'(1) << 30)) s = longint'(1) << 30;
         rom[j] = 17'((64'(s) + 64'd8192) >> 14);
      end
      return rom;
   endfunction

   // exact floor(65536 * (idx / 2^G)^(5/11))
   function automatic gamma_rom_type gamma_table();
      gamma_rom_type rom;
      logic [191:0]  tgt;
      logic [191:0]  pw;
      logic [16:0]   lo;
      logic [16:0]   hi;
      logic [16:0]   mid;
      for (int i = 0; i <= GAMMA_Q; i++) begin
         tgt = 192'd1;
         for (int n = 0; n < 5; n++) tgt = tgt * 192'(i);
         tgt = tgt << (176 - 5 * GAMMA_BITS);
         lo  = 17'd0;
         hi  = 17'd65536;
         for (int step = 0; step < 17; step++) begin
            if (lo < hi) begin
               mid = 17'((18'(lo) + 18'(hi) + 18'd1) >> 1);
               pw  = 192'd1;
               for (int n = 0; n < 11; n++) pw = pw * 192'(mid);
               if (pw <= tgt) lo = mid;
               else           hi = mid - 17'd1;
            end
         end
         rom[i] = lo;
      end
      return rom;
   endfunction

   localparam sin_rom_type   SIN_ROM   = sin_table();
   localparam gamma_rom_type GAMMA_ROM = gamma_table();

   // Q24 coefficients rounded from ten-decimal values
   localparam longint DEC_SCALE = 64'd10000000000;
   localparam longint ONE_Q24   = 64'd16777216;

   localparam logic signed [27:0] LK0 = 28'((64'd3963377774 * ONE_Q24 + DEC_SCALE / 2) / DEC_SCALE);
   localparam logic signed [27:0] LK1 = 28'((64'd2158037573 * ONE_Q24 + DEC_SCALE / 2) / DEC_SCALE);
   localparam logic signed [27:0] LK2 = 28'((64'd1055613458 * ONE_Q24 + DEC_SCALE / 2) / DEC_SCALE);
   localparam logic signed [27:0] LK3 = 28'((64'd638541728 * ONE_Q24 + DEC_SCALE / 2) / DEC_SCALE);
   localparam logic signed [27:0] LK4 = 28'((64'd894841775 * ONE_Q24 + DEC_SCALE / 2) / DEC_SCALE);
   localparam logic signed [27:0] LK5 = 28'((64'd12914855480 * ONE_Q24 + DEC_SCALE / 2) / DEC_SCALE);

   localparam logic signed [27:0] RK0 = 28'((64'd40767416621 * ONE_Q24 + DEC_SCALE / 2) / DEC_SCALE);
   localparam logic signed [27:0] RK1 = -28'((64'd33077115913 * ONE_Q24 + DEC_SCALE / 2) / DEC_SCALE);
   localparam logic signed [27:0] RK2 = 28'((64'd2309699292 * ONE_Q24 + DEC_SCALE / 2) / DEC_SCALE);
   localparam logic signed [27:0] RK3 = -28'((64'd12684380046 * ONE_Q24 + DEC_SCALE / 2) / DEC_SCALE);
   localparam logic signed [27:0] RK4 = 28'((64'd26097574011 * ONE_Q24 + DEC_SCALE / 2) / DEC_SCALE);
   localparam logic signed [27:0] RK5 = -28'((64'd3413193965 * ONE_Q24 + DEC_SCALE / 2) / DEC_SCALE);
   localparam logic signed [27:0] RK6 = -28'((64'd41960863 * ONE_Q24 + DEC_SCALE / 2) / DEC_SCALE);
   localparam logic signed [27:0] RK7 = -28'((64'd7034186147 * ONE_Q24 + DEC_SCALE / 2) / DEC_SCALE);
   localparam logic signed [27:0] RK8 = 28'((64'd17076147010 * ONE_Q24 + DEC_SCALE / 2) / DEC_SCALE);

   // values that ride along the pipe beside the colour maths
   typedef struct packed {
      logic signed [23:0] light;
      logic signed [23:0] gain;
      logic        [16:0] alpha;
   } side_type;

   // pipe control handed to every section
   typedef struct packed {
      logic adv;
      logic valid;
   } pipe_ctl_type;

   typedef logic signed [36:0] cube_type;
   typedef logic signed [31:0] chan_type;

endpackage

`default_nettype wire

// ----- hw/rtl/okrgb_trig.sv -----
// ----------------------------------------------------------------------------
// okrgb_trig
// First stage: hue quadrant fold, sine table look-up and alpha clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module okrgb_trig (
   input  wire                        clock,
   input  wire                        reset,
   input  okrgb_pkg::pipe_ctl_type    ctl,
   input  wire logic signed [23:0]    hue_turns,
   input  wire logic signed [23:0]    chroma,
   input  wire logic signed [23:0]    lightness,
   input  wire logic signed [23:0]    alpha_in,
   input  wire logic signed [23:0]    gain,
   output logic                       valid_ff,
   output logic signed [17:0]         cos_ff,
   output logic signed [17:0]         sin_ff,
   output logic signed [23:0]         chroma_ff,
   output okrgb_pkg::side_type        side_ff
);
   import okrgb_pkg::*;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;

   logic [TRIG_BITS-1:0] phase;
   logic [1:0]           quad;
   logic [TRIG_JW:0]     up_idx;
   logic [TRIG_JW:0]     dn_idx;
   logic signed [17:0]   up;
   logic signed [17:0]   dn;
   logic signed [17:0]   cos_in;
   logic signed [17:0]   sin_in;
   logic [16:0]          alpha_c;

   assign phase  = hue_turns[15 -: TRIG_BITS];
   assign quad   = phase[TRIG_BITS-1 -: 2];
   assign up_idx = {1'b0, phase[TRIG_JW-1:0]};
   assign dn_idx = (TRIG_JW + 1)'(TRIG_Q) - up_idx;
   assign up     = $signed({1'b0, SIN_ROM[up_idx]});
   assign dn     = $signed({1'b0, SIN_ROM[dn_idx]});

   always_comb begin
      case (quad)
         QUAD_0: begin sin_in = up;  cos_in = dn;  end
         QUAD_1: begin sin_in = dn;  cos_in = -up; end
         QUAD_2: begin sin_in = -up; cos_in = -dn; end
         default: begin sin_in = -dn; cos_in = up; end
      endcase
   end

   always_comb begin
      if (alpha_in < 0)                 alpha_c = 17'd0;
      else if (alpha_in > 24'sd65536)   alpha_c = 17'd65536;
      else                              alpha_c = alpha_in[16:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.adv) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         cos_ff        <= cos_in;
         sin_ff        <= sin_in;
         chroma_ff     <= chroma;
         side_ff.light <= lightness;
         side_ff.gain  <= gain;
         side_ff.alpha <= alpha_c;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/okrgb_lab.sv -----
// ----------------------------------------------------------------------------
// okrgb_lab
// OKLab a/b, OKLab-to-LMS matrix and per-channel cube over five stages.
// ----------------------------------------------------------------------------
`default_nettype none

module okrgb_lab (
   input  wire                        clock,
   input  wire                        reset,
   input  okrgb_pkg::pipe_ctl_type    ctl,
   input  wire logic signed [17:0]    cos_v,
   input  wire logic signed [17:0]    sin_v,
   input  wire logic signed [23:0]    chroma,
   input  okrgb_pkg::side_type        side,
   output logic                       valid_ff,
   output okrgb_pkg::cube_type        cube_ff [3],
   output okrgb_pkg::side_type        side_ff
);
   import okrgb_pkg::*;

   localparam logic signed [57:0] LMS_MAX = 58'sd32 <<< 20;
   localparam logic signed [57:0] LMS_MIN = -(58'sd32 <<< 20);

   // stage valids, oldest last
   logic [3:0]          vld_ff;

   // a/b stage
   logic signed [41:0]  pa;
   logic signed [41:0]  pb;
   logic signed [28:0]  a_ff;
   logic signed [28:0]  b_ff;
   logic        [20:0]  lc_in;
   logic        [20:0]  lc2_ff;
   side_type            s2_ff;

   // matrix products
   logic signed [55:0]  prod_ff [6];
   logic        [20:0]  lc3_ff;
   side_type            s3_ff;

   // lms sums
   logic signed [57:0]  t_in [3];
   logic signed [57:0]  v_in [3];
   logic signed [26:0]  x4_ff [3];
   side_type            s4_ff;

   // square
   logic signed [53:0]  sq_p [3];
   logic signed [31:0]  sq_ff [3];
   logic signed [26:0]  x5_ff [3];
   side_type            s5_ff;

   logic signed [58:0]  cu_p [3];

   assign pa = 42'(chroma) * 42'(cos_v) + 42'sd2048;
   assign pb = 42'(chroma) * 42'(sin_v) + 42'sd2048;

   always_comb begin
      if (side.light < 0)                lc_in = 21'd0;
      else if (side.light > 24'sd65536)  lc_in = 21'd1 << 20;
      else                               lc_in = {side.light[16:0], 4'd0};
   end

   always_comb begin
      t_in[0] = (58'(prod_ff[0]) + 58'(prod_ff[1]) + (58'sd1 <<< 23)) >>> 24;
      t_in[1] = (58'(prod_ff[2]) + 58'(prod_ff[3]) + (58'sd1 <<< 23)) >>> 24;
      t_in[2] = (58'(prod_ff[4]) + 58'(prod_ff[5]) + (58'sd1 <<< 23)) >>> 24;
      v_in[0] = $signed({37'd0, lc3_ff}) + t_in[0];
      v_in[1] = $signed({37'd0, lc3_ff}) - t_in[1];
      v_in[2] = $signed({37'd0, lc3_ff}) - t_in[2];
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sq_p[c] = 54'(x4_ff[c]) * 54'(x4_ff[c]) + (54'sd1 <<< 19);
         cu_p[c] = 59'(sq_ff[c]) * 59'(x5_ff[c]) + (59'sd1 <<< 19);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         valid_ff <= 1'b0;
      end else if (ctl.adv) begin
         vld_ff   <= {vld_ff[2:0], ctl.valid};
         valid_ff <= vld_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         // a, b in Q20
         a_ff   <= pa[40:12];
         b_ff   <= pb[40:12];
         lc2_ff <= lc_in;
         s2_ff  <= side;
         // matrix products, Q44
         prod_ff[0] <= 56'(LK0) * 56'(a_ff);
         prod_ff[1] <= 56'(LK1) * 56'(b_ff);
         prod_ff[2] <= 56'(LK2) * 56'(a_ff);
         prod_ff[3] <= 56'(LK3) * 56'(b_ff);
         prod_ff[4] <= 56'(LK4) * 56'(a_ff);
         prod_ff[5] <= 56'(LK5) * 56'(b_ff);
         lc3_ff     <= lc2_ff;
         s3_ff      <= s2_ff;
         // saturate l, m, s before the cube
         for (int c = 0; c < 3; c++) begin
            if (v_in[c] > LMS_MAX)      x4_ff[c] <= LMS_MAX[26:0];
            else if (v_in[c] < LMS_MIN) x4_ff[c] <= LMS_MIN[26:0];
            else                        x4_ff[c] <= v_in[c][26:0];
            sq_ff[c]   <= sq_p[c][51:20];
            x5_ff[c]   <= x4_ff[c];
            cube_ff[c] <= cu_p[c][56:20];
         end
         s4_ff   <= s3_ff;
         s5_ff   <= s4_ff;
         side_ff <= s5_ff;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/okrgb_rgb.sv -----
// ----------------------------------------------------------------------------
// okrgb_rgb
// LMS-to-linear-sRGB matrix, gamma table, HDR scale and gain with saturation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module okrgb_rgb (
   input  wire                        clock,
   input  wire                        reset,
   input  okrgb_pkg::pipe_ctl_type    ctl,
   input  okrgb_pkg::cube_type        cube [3],
   input  okrgb_pkg::side_type        side,
   output logic                       valid_ff,
   output okrgb_pkg::chan_type        rgb_ff [3],
   output logic [16:0]                alpha_ff
);
   import okrgb_pkg::*;

   localparam int LIN_RND = 1 << (19 - GAMMA_BITS);

   logic [3:0]             vld_ff;

   logic signed [64:0]     prod_ff [9];
   side_type               s7_ff;

   logic signed [66:0]     sum_in [3];
   logic signed [66:0]     lin_in [3];
   logic        [20:0]     linc_in [3];
   logic        [21:0]     idx_w [3];
   logic [GAMMA_IW-1:0]    idx_ff [3];
   side_type               s8_ff;

   logic        [16:0]     y_ff [3];
   side_type               s9_ff;

   logic signed [41:0]     hdr_p [3];
   logic signed [24:0]     yh_ff [3];
   side_type               s10_ff;

   logic signed [48:0]     g_p [3];
   logic signed [48:0]     g_s [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum_in[c] = 67'(prod_ff[3*c]) + 67'(prod_ff[3*c+1]) + 67'(prod_ff[3*c+2])
                   + (67'sd1 <<< 23);
         lin_in[c] = sum_in[c] >>> 24;
         if (lin_in[c] < 0)                     linc_in[c] = 21'd0;
         else if (lin_in[c] > (67'sd1 <<< 20))  linc_in[c] = 21'd1 << 20;
         else                                   linc_in[c] = lin_in[c][20:0];
         idx_w[c] = (22'(linc_in[c]) + 22'(LIN_RND)) >> (20 - GAMMA_BITS);
         hdr_p[c] = 42'($signed({1'b0, y_ff[c]})) * 42'(s9_ff.light) + (42'sd1 <<< 15);
         g_p[c]   = 49'(yh_ff[c]) * 49'(s10_ff.gain) + (49'sd1 <<< 15);
         g_s[c]   = g_p[c] >>> 16;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         valid_ff <= 1'b0;
      end else if (ctl.adv) begin
         vld_ff   <= {vld_ff[2:0], ctl.valid};
         valid_ff <= vld_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         prod_ff[0] <= 65'(RK0) * 65'(cube[0]);
         prod_ff[1] <= 65'(RK1) * 65'(cube[1]);
         prod_ff[2] <= 65'(RK2) * 65'(cube[2]);
         prod_ff[3] <= 65'(RK3) * 65'(cube[0]);
         prod_ff[4] <= 65'(RK4) * 65'(cube[1]);
         prod_ff[5] <= 65'(RK5) * 65'(cube[2]);
         prod_ff[6] <= 65'(RK6) * 65'(cube[0]);
         prod_ff[7] <= 65'(RK7) * 65'(cube[1]);
         prod_ff[8] <= 65'(RK8) * 65'(cube[2]);
         s7_ff      <= side;
         for (int c = 0; c < 3; c++) begin
            idx_ff[c] <= idx_w[c][GAMMA_IW-1:0];
            // registered table read
            y_ff[c]   <= GAMMA_ROM[idx_ff[c]];
            // lightness above one scales the colour
            if (s9_ff.light > 24'sd65536) yh_ff[c] <= hdr_p[c][40:16];
            else                          yh_ff[c] <= $signed({8'd0, y_ff[c]});
            if (g_s[c] > 49'sh7FFFFFFF)       rgb_ff[c] <= 32'sh7FFFFFFF;
            else if (g_s[c] < -49'sh80000000) rgb_ff[c] <= 32'sh80000000;
            else                              rgb_ff[c] <= g_s[c][31:0];
         end
         s8_ff    <= s7_ff;
         s9_ff    <= s8_ff;
         s10_ff   <= s9_ff;
         alpha_ff <= s10_ff.alpha;
      end
   end

   `OKRGB_ASSERT_NOW(a_gamma_idx_range, clock, reset, vld_ff[1], (idx_ff[0] <= GAMMA_IW'(GAMMA_Q)) && (idx_ff[1] <= GAMMA_IW'(GAMMA_Q)) && (idx_ff[2] <= GAMMA_IW'(GAMMA_Q)), "gamma index beyond table")

endmodule

`default_nettype wire

// ----- hw/rtl/oklch_to_rgba_color.sv -----
// ----------------------------------------------------------------------------
// oklch_to_rgba_color
// OKLCh to gamma-encoded RGBA, one colour per word, pipelined.
// ----------------------------------------------------------------------------
//  channel  dir  group   payload
//  request  in   req_*   hue, chroma, lightness, alpha, gain (Q7.16 each)
//  response out  rsp_*   red, green, blue (Q15.16), alpha (Q1.16)
//
//  One word in per clock, except while the output is stalled.
//  Stages: sine table, a/b, matrix products, lms sum, square, cube, rgb
//  products, linear sum and table index, gamma table read, HDR scale, gain.
//  Reset is synchronous and clears only the stage valid bits.
//  The whole pipe advances when the output stage is empty or being taken;
//  on a stall every stage holds, so no word is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module oklch_to_rgba_color (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // [23:0] hue_turns, [47:24] chroma, [71:48] lightness,
   // [95:72] alpha_in, [119:96] gain
   input  wire  [119:0] req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // [31:0] red, [63:32] green, [95:64] blue, [112:96] alpha_out, rest zero
   output logic [119:0] rsp_tdata
);
   import okrgb_pkg::*;

   logic                adv;
   pipe_ctl_type        ctl_in;
   pipe_ctl_type        ctl_lab;
   pipe_ctl_type        ctl_rgb;

   logic                trig_vld;
   logic signed [17:0]  trig_cos;
   logic signed [17:0]  trig_sin;
   logic signed [23:0]  trig_chroma;
   side_type            trig_side;

   logic                lab_vld;
   cube_type            lab_cube [3];
   side_type            lab_side;

   chan_type            rgb [3];
   logic [16:0]         alpha_out;

   // advance everything when the output slot is free or draining
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   assign ctl_in  = '{adv: adv, valid: req_tvalid};
   assign ctl_lab = '{adv: adv, valid: trig_vld};
   assign ctl_rgb = '{adv: adv, valid: lab_vld};

   okrgb_trig u_trig (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_in),
      .hue_turns (req_tdata[23:0]),
      .chroma    (req_tdata[47:24]),
      .lightness (req_tdata[71:48]),
      .alpha_in  (req_tdata[95:72]),
      .gain      (req_tdata[119:96]),
      .valid_ff  (trig_vld),
      .cos_ff    (trig_cos),
      .sin_ff    (trig_sin),
      .chroma_ff (trig_chroma),
      .side_ff   (trig_side)
   );

   okrgb_lab u_lab (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl_lab),
      .cos_v    (trig_cos),
      .sin_v    (trig_sin),
      .chroma   (trig_chroma),
      .side     (trig_side),
      .valid_ff (lab_vld),
      .cube_ff  (lab_cube),
      .side_ff  (lab_side)
   );

   okrgb_rgb u_rgb (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl_rgb),
      .cube     (lab_cube),
      .side     (lab_side),
      .valid_ff (rsp_tvalid),
      .rgb_ff   (rgb),
      .alpha_ff (alpha_out)
   );

   // pack the result word, red lowest
   assign rsp_tdata = {7'd0, alpha_out, rgb[2], rgb[1], rgb[0]};

   `OKRGB_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready, "input blocked with empty output stage")
   `OKRGB_ASSERT_NOW(a_stall_blocks_input, clock, reset, rsp_tvalid && !rsp_tready, !req_tready, "input taken while output stalled")
   `OKRGB_ASSERT_NEXT(a_stall_holds_word, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result word changed while stalled")
   `OKRGB_ASSERT_NOW(a_alpha_range, clock, reset, rsp_tvalid, alpha_out <= 17'd65536, "alpha out of range")

endmodule

`default_nettype wire

// ----- test/oklch_to_rgba_color_tb.sv -----
// ----------------------------------------------------------------------------
// oklch_to_rgba_color_tb
// Self-checking bench for the OKLCh to RGBA converter: a bursty driver feeds
// colour words, a monitor with its own stall pattern compares every result
// word against an independent fixed-point model of the conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module oklch_to_rgba_color_tb;

   localparam int TRIG_BITS   = 10;
   localparam int GAMMA_BITS  = 10;
   localparam int QUARTER     = 1 << (TRIG_BITS - 2);
   localparam int GAMMA_SIZE  = 1 << GAMMA_BITS;
   localparam int PIPE_DEPTH  = 11;
   localparam int N_RANDOM    = 900;
   localparam longint CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic signed [23:0] gain;
      logic signed [23:0] alpha_in;
      logic signed [23:0] lightness;
      logic signed [23:0] chroma;
      logic signed [23:0] hue_turns;
   } colour_word_type;

   typedef struct packed {
      logic [16:0]        alpha_out;
      logic signed [31:0] blue;
      logic signed [31:0] green;
      logic signed [31:0] red;
   } rgba_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [119:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;

   oklch_to_rgba_color u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   colour_word_type pending_colours[$];
   rgba_word_type   expected_rgba[$];
   longint          sine_q16  [0:QUARTER];
   longint          gamma_q16 [0:GAMMA_SIZE];
   longint          lab_coef  [0:5];
   longint          rgb_coef  [0:8];
   bit              failed = 1'b0;
   bit              stimulus_done = 1'b0;
   longint          cycle_count = 0;

   // Q24 coefficient from a ten-decimal fixed value
   function automatic longint q24(longint dec);
      return (dec * 16777216 + 64'sd5000000000) / 64'sd10000000000;
   endfunction

   // round half up: floor((v + 2^(s-1)) / 2^s)
   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // exact floor(65536 * (idx/2^G)^(5/11)) by bisection on 11th powers
   function automatic longint gamma_entry(int idx);
      logic [191:0] bound;
      logic [191:0] pw;
      longint       lo;
      longint       hi;
      longint       mid;
      lo = 0;
      hi = 65536;
      bound = 192'(idx) * 192'(idx) * 192'(idx) * 192'(idx) * 192'(idx);
      bound = bound << (176 - 5 * GAMMA_BITS);
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         pw = 192'd1;
         for (int n = 0; n < 11; n++) pw = pw * 192'(mid);
         if (pw <= bound) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   // Q30 Taylor sine at j/Q of a quarter turn, rounded to Q1.16
   function automatic longint sine_entry(int j);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      x = (longint'(j) * 64'd1686629713 + (64'd1 << (TRIG_BITS - 3))) >> (TRIG_BITS - 2);
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      acc = x;
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) acc -= term;
         else acc += term;
      end
      acc = clip(acc, 0, longint'(1) << 30);
      return (acc + 8192) >>> 14;
   endfunction

   function automatic longint cube_q20(longint x);
      longint sq;
      x = clip(x, -(longint'(32) << 20), longint'(32) << 20);
      sq = round_shift(x * x, 20);
      return round_shift(sq * x, 20);
   endfunction

   function automatic rgba_word_type convert_colour(colour_word_type c);
      rgba_word_type r;
      int         phase;
      int         quad;
      int         j;
      longint     up;
      longint     dn;
      longint     cs;
      longint     sn;
      longint     lab_a;
      longint     lab_b;
      longint     lq;
      longint     light;
      longint     gn;
      longint     lms [0:2];
      longint     lin;
      longint     y;
      longint     chan [0:2];
      int         idx;
      phase = int'(c.hue_turns[15:0]) >> (16 - TRIG_BITS);
      quad = (phase >> (TRIG_BITS - 2)) & 3;
      j = phase & (QUARTER - 1);
      up = sine_q16[j];
      dn = sine_q16[QUARTER - j];
      case (quad)
         0: begin sn = up;  cs = dn;  end
         1: begin sn = dn;  cs = -up; end
         2: begin sn = -up; cs = -dn; end
         default: begin sn = -dn; cs = up; end
      endcase
      lab_a = round_shift(longint'(c.chroma) * cs, 12);
      lab_b = round_shift(longint'(c.chroma) * sn, 12);
      light = c.lightness;
      gn = c.gain;
      lq = clip(light, 0, 65536) << 4;
      lms[0] = cube_q20(lq + round_shift(lab_coef[0] * lab_a + lab_coef[1] * lab_b, 24));
      lms[1] = cube_q20(lq - round_shift(lab_coef[2] * lab_a + lab_coef[3] * lab_b, 24));
      lms[2] = cube_q20(lq - round_shift(lab_coef[4] * lab_a + lab_coef[5] * lab_b, 24));
      for (int ch = 0; ch < 3; ch++) begin
         lin = round_shift(rgb_coef[3*ch] * lms[0] + rgb_coef[3*ch+1] * lms[1]
                           + rgb_coef[3*ch+2] * lms[2], 24);
         lin = clip(lin, 0, longint'(1) << 20);
         idx = int'((lin + (longint'(1) << (19 - GAMMA_BITS))) >> (20 - GAMMA_BITS));
         y = gamma_q16[idx];
         if (light > 65536) y = round_shift(y * light, 16);
         chan[ch] = clip(round_shift(y * gn, 16), -(longint'(1) << 31),
                         (longint'(1) << 31) - 1);
      end
      r.red = 32'(chan[0]);
      r.green = 32'(chan[1]);
      r.blue = 32'(chan[2]);
      r.alpha_out = 17'(clip(longint'(c.alpha_in), 0, 65536));
      return r;
   endfunction

   function automatic logic [23:0] pick_q716();
      case ($urandom_range(0, 9))
         0: return 24'($urandom);
         1: return 24'h7FFFFF;
         2: return 24'h800000;
         3: return 24'(-$urandom_range(0, 65536));
         default: return 24'($urandom_range(0, 131072));
      endcase
   endfunction

   task automatic queue_colour(logic [23:0] h, logic [23:0] ch, logic [23:0] l,
                               logic [23:0] a, logic [23:0] g);
      colour_word_type w;
      w.hue_turns = h;
      w.chroma = ch;
      w.lightness = l;
      w.alpha_in = a;
      w.gain = g;
      pending_colours = {pending_colours, w};
   endtask

   initial begin
      lab_coef = '{q24(64'sd3963377774), q24(64'sd2158037573), q24(64'sd1055613458),
                   q24(64'sd638541728), q24(64'sd894841775), q24(64'sd12914855480)};
      rgb_coef = '{q24(64'sd40767416621), -q24(64'sd33077115913), q24(64'sd2309699292),
                   -q24(64'sd12684380046), q24(64'sd26097574011), -q24(64'sd3413193965),
                   -q24(64'sd41960863), -q24(64'sd7034186147), q24(64'sd17076147010)};
      for (int j = 0; j <= QUARTER; j++) sine_q16[j] = sine_entry(j);
      for (int i = 0; i <= GAMMA_SIZE; i++) gamma_q16[i] = gamma_entry(i);

      // directed: grey, each quadrant, negative hue, lightness and gain
      // extremes, HDR, alpha out of range, extreme chroma
      queue_colour(24'h0, 24'h0, 24'h8000, 24'h8000, 24'h10000);
      queue_colour(24'h4000, 24'h2000, 24'h10000, 24'h10000, 24'h10000);
      queue_colour(24'h8000, 24'h2000, 24'h8000, 24'h0, 24'h10000);
      queue_colour(24'hC000, 24'h2000, 24'h8000, 24'h0, 24'h10000);
      queue_colour(24'hFFFFFF, 24'h3000, 24'h9000, 24'hFFFFFF, 24'h10000);
      queue_colour(24'h812345, 24'h1000, 24'h800000, 24'h800000, 24'h10000);
      queue_colour(24'h1234, 24'h0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      queue_colour(24'h1234, 24'h0, 24'h7FFFFF, 24'h20000, 24'h800000);
      queue_colour(24'h2222, 24'h7FFFFF, 24'h8000, 24'h10001, 24'h10000);
      queue_colour(24'hA000, 24'h800000, 24'h8000, 24'hFFFF, 24'h10000);
      queue_colour(24'h5555, 24'h4000, 24'h18000, 24'h1, 24'hFF0000);
      queue_colour(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h0, 24'h7FFFFF);
      queue_colour(24'h3F00, 24'h1800, 24'h10000, 24'h10000, 24'h0);
      queue_colour(24'hFFFF, 24'h1800, 24'h10001, 24'h8000, 24'h10000);

      // mostly plausible colours, with full-range noise mixed in
      for (int n = 0; n < N_RANDOM; n++) begin
         if ($urandom_range(0, 3) == 0)
            queue_colour(24'($urandom), pick_q716(), pick_q716(), pick_q716(), pick_q716());
         else
            queue_colour(24'($urandom), 24'($urandom_range(0, 26000)),
                         24'($urandom_range(0, 90000)), 24'($urandom_range(0, 65536)),
                         24'($urandom_range(0, 200000)));
      end
      stimulus_done = 1'b1;
   end

   // driver: bursts of random length, random gaps between them
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == 7) reset <= 1'b0;
      if (!reset) begin
         // advance when the word on the bus is taken or nothing is offered
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_colours.size() > 0) begin
               req_tdata <= pending_colours[0];
               expected_rgba = {expected_rgba, convert_colour(pending_colours[0])};
               void'(pending_colours.pop_front());
               req_tvalid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver stall: long open stretches alternating with choppy ones
   int stall_phase = 0;

   always @(posedge clock) begin
      stall_phase <= (stall_phase + 1) % 300;
      if (stall_phase < 100) rsp_tready <= 1'b1;
      else if (stall_phase < 200) rsp_tready <= ($urandom_range(0, 3) != 0);
      else rsp_tready <= ($urandom_range(0, 2) == 0);
   end

   // monitor: compare each taken word with the oldest expectation
   always @(posedge clock) begin
      rgba_word_type got;
      rgba_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[112:0];
         if (expected_rgba.size() == 0) begin
            $display("%0t: unexpected word %h", $time, rsp_tdata);
            failed = 1'b1;
         end else begin
            want = expected_rgba.pop_front();
            if (got.red !== want.red) begin
               $display("%0t: red exp %0d got %0d", $time, want.red, got.red);
               failed = 1'b1;
            end
            if (got.green !== want.green) begin
               $display("%0t: green exp %0d got %0d", $time, want.green, got.green);
               failed = 1'b1;
            end
            if (got.blue !== want.blue) begin
               $display("%0t: blue exp %0d got %0d", $time, want.blue, got.blue);
               failed = 1'b1;
            end
            if (got.alpha_out !== want.alpha_out) begin
               $display("%0t: alpha exp %0d got %0d", $time, want.alpha_out, got.alpha_out);
               failed = 1'b1;
            end
         end
      end
   end

   // end of run: drain, let the pipe settle, then report
   initial begin
      wait (stimulus_done && !reset);
      while ((pending_colours.size() > 0 || req_tvalid || expected_rgba.size() > 0)
             && cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
      end else begin
         repeat (4 * PIPE_DEPTH) @(posedge clock);
         if (!failed) $display("[ OK ] regression clean");
         else $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
